### src/assert_macros.svh
// Assertion macros for the counter bank RTL.
// No dependencies; pulled in by `include where checks are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while the active-low reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/usgcnt_pkg.sv
`timescale 1ns / 1ps
// Types and constants for the usage statistics counter bank.
// No dependencies; imported by the top level.
package usgcnt_pkg;

    localparam int DEFAULT_PRESETS = 8;

    localparam int OP_W     = 4;
    localparam int PRESET_W = 8;
    localparam int VALUE_W  = 32;
    localparam int CAUSE_W  = 16;
    localparam int INDEX_W  = 6;
    localparam int CNT_W    = 32;
    localparam int NARROW_W = 16;
    localparam int MS_W     = 10;

    // tdata packing, lowest field first, padded to whole bytes
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 72;

    localparam logic [MS_W-1:0]     MS_LAST     = 10'd999;
    localparam logic [NARROW_W-1:0] SAT16       = 16'hFFFF;
    localparam int                  WATCHDOG_BIT = 0;

    typedef enum logic [OP_W-1:0] {
        OP_ON      = 4'd0,
        OP_ADDTIME = 4'd1,
        OP_LATCH   = 4'd2,
        OP_PRESS   = 4'd3,
        OP_CAUSE   = 4'd4,
        OP_BOOT    = 4'd5,
        OP_CLEAR   = 4'd6,
        OP_MSTICK  = 4'd7,
        OP_READ    = 4'd8,
        OP_RESTORE = 4'd9
    } t_op;

    localparam logic [INDEX_W-1:0] IDX_TOTAL_CNT = 6'd0;
    localparam logic [INDEX_W-1:0] IDX_TOTAL_SEC = 6'd1;
    localparam logic [INDEX_W-1:0] IDX_LATCH     = 6'd2;
    localparam logic [INDEX_W-1:0] IDX_PRESS     = 6'd3;
    localparam logic [INDEX_W-1:0] IDX_OPER_SEC  = 6'd4;
    localparam logic [INDEX_W-1:0] IDX_WATCHDOG  = 6'd5;
    localparam logic [INDEX_W-1:0] IDX_BOOT      = 6'd6;
    localparam logic [INDEX_W-1:0] IDX_PRESET0   = 6'd8;

endpackage

### src/usage_statistics_counter_bank_unit.sv
`timescale 1ns / 1ps
// Usage statistics counter bank: each item passes an input register, one
// combinational update of the counters, and a result register. Throughput one
// item per cycle while the result side accepts each result.
// Either side may stall; the input register holds while the result waits.
// Synchronous active-low reset zeroes all counters, flags and valid bits.
// Depends on usgcnt_pkg and assert_macros.svh.
module usage_statistics_counter_bank_unit #(
    parameter int PRESETS = usgcnt_pkg::DEFAULT_PRESETS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // operation[3:0], preset[11:4], value[43:12], cause_bits[59:44], index[65:60], pad
    input  logic [usgcnt_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // read_data[31:0], clamped_data[47:32], boot_total[63:48], index_valid[64], pad
    output logic [usgcnt_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import usgcnt_pkg::*;

    localparam int AW = (PRESETS > 1) ? $clog2(PRESETS) : 1;

    // input register
    logic                r_in_valid;
    logic [OP_W-1:0]     r_op;
    logic [PRESET_W-1:0] r_preset;
    logic [VALUE_W-1:0]  r_value;
    logic [CAUSE_W-1:0]  r_cause;
    logic [INDEX_W-1:0]  r_index;

    // counter state
    logic [NARROW_W-1:0] r_boot,   n_boot;
    logic [CNT_W-1:0]    r_on_cnt [PRESETS];
    logic [CNT_W-1:0]    n_on_cnt [PRESETS];
    logic [CNT_W-1:0]    r_on_sec [PRESETS];
    logic [CNT_W-1:0]    n_on_sec [PRESETS];
    logic [CNT_W-1:0]    r_latch,  n_latch;
    logic [CNT_W-1:0]    r_press,  n_press;
    logic [CNT_W-1:0]    r_oper,   n_oper;
    logic [MS_W-1:0]     r_ms_rem, n_ms_rem;
    logic [NARROW_W-1:0] r_wd_cnt, n_wd_cnt;
    logic                r_wd_pend, n_wd_pend;
    logic [CNT_W-1:0]    r_tot_cnt, n_tot_cnt;
    logic [CNT_W-1:0]    r_tot_sec, n_tot_sec;

    // result register
    logic                 r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data, n_out_data;

    logic                 advance;
    logic                 preset_ok;
    logic                 idx_preset_ok;
    logic                 idx_ok;
    logic [PRESET_W-1:0]  preset_m1;
    logic [INDEX_W-1:0]   idx_off;
    logic [AW-1:0]        slot;
    logic [CNT_W-1:0]     cur_cnt;
    logic [CNT_W-1:0]     cur_sec;
    logic [CNT_W-1:0]     rd;
    logic                 is_access;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign preset_m1     = r_preset - 8'd1;
    assign preset_ok     = (r_preset != '0) && (r_preset <= PRESET_W'(PRESETS));
    assign idx_off       = r_index - IDX_PRESET0;
    assign idx_preset_ok = (r_index >= IDX_PRESET0) &&
                           ({1'b0, idx_off[INDEX_W-1:1]} < INDEX_W'(PRESETS));
    assign idx_ok        = (r_index <= IDX_BOOT) || idx_preset_ok;
    assign is_access     = (r_op == OP_READ) || (r_op == OP_RESTORE);
    assign slot          = is_access ? idx_off[AW:1] : preset_m1[AW-1:0];
    assign cur_cnt       = r_on_cnt[slot];
    assign cur_sec       = r_on_sec[slot];

    always_comb begin
        n_boot    = r_boot;
        n_on_cnt  = r_on_cnt;
        n_on_sec  = r_on_sec;
        n_latch   = r_latch;
        n_press   = r_press;
        n_oper    = r_oper;
        n_ms_rem  = r_ms_rem;
        n_wd_cnt  = r_wd_cnt;
        n_wd_pend = r_wd_pend;
        n_tot_cnt = r_tot_cnt;
        n_tot_sec = r_tot_sec;
        if (advance) begin
            case (r_op)
                OP_ON: begin
                    if (preset_ok) begin
                        n_on_cnt[slot] = cur_cnt + 32'd1;
                        n_tot_cnt      = r_tot_cnt + 32'd1;
                    end
                end
                OP_ADDTIME: begin
                    if (preset_ok) begin
                        n_on_sec[slot] = cur_sec + r_value;
                        n_tot_sec      = r_tot_sec + r_value;
                    end
                end
                OP_LATCH: n_latch = r_latch + 32'd1;
                OP_PRESS: n_press = r_press + 32'd1;
                OP_CAUSE: begin
                    if (r_cause[WATCHDOG_BIT]) begin
                        n_wd_pend = 1'b1;
                    end
                end
                OP_BOOT: begin
                    n_boot = r_boot + 16'd1;
                    if (r_wd_pend) begin
                        n_wd_pend = 1'b0;
                        if (r_wd_cnt != SAT16) begin
                            n_wd_cnt = r_wd_cnt + 16'd1;
                        end
                    end
                end
                OP_CLEAR: begin
                    for (int i = 0; i < PRESETS; i++) begin
                        n_on_cnt[i] = '0;
                        n_on_sec[i] = '0;
                    end
                    n_latch   = '0;
                    n_press   = '0;
                    n_oper    = '0;
                    n_ms_rem  = '0;
                    n_wd_cnt  = '0;
                    n_tot_cnt = '0;
                    n_tot_sec = '0;
                end
                OP_MSTICK: begin
                    if (r_ms_rem >= MS_LAST) begin
                        n_ms_rem = '0;
                        n_oper   = r_oper + 32'd1;
                    end else begin
                        n_ms_rem = r_ms_rem + 10'd1;
                    end
                end
                OP_RESTORE: begin
                    case (r_index)
                        IDX_LATCH:    n_latch  = r_value;
                        IDX_PRESS:    n_press  = r_value;
                        IDX_OPER_SEC: n_oper   = r_value;
                        IDX_WATCHDOG: n_wd_cnt = r_value[NARROW_W-1:0];
                        IDX_BOOT:     n_boot   = r_value[NARROW_W-1:0];
                        default: begin
                            if (idx_preset_ok) begin
                                if (!r_index[0]) begin
                                    n_on_cnt[slot] = r_value;
                                    n_tot_cnt      = r_tot_cnt + (r_value - cur_cnt);
                                end else begin
                                    n_on_sec[slot] = r_value;
                                    n_tot_sec      = r_tot_sec + (r_value - cur_sec);
                                end
                            end
                        end
                    endcase
                end
                default: ;
            endcase
        end
    end

    // read view of the state after this item
    always_comb begin
        rd = '0;
        if (is_access) begin
            case (r_index)
                IDX_TOTAL_CNT: rd = n_tot_cnt;
                IDX_TOTAL_SEC: rd = n_tot_sec;
                IDX_LATCH:     rd = n_latch;
                IDX_PRESS:     rd = n_press;
                IDX_OPER_SEC:  rd = n_oper;
                IDX_WATCHDOG:  rd = {16'd0, n_wd_cnt};
                IDX_BOOT:      rd = {16'd0, n_boot};
                default: begin
                    if (idx_preset_ok) begin
                        if (r_op == OP_RESTORE) begin
                            rd = r_value;
                        end else begin
                            rd = r_index[0] ? cur_sec : cur_cnt;
                        end
                    end
                end
            endcase
        end
    end

    always_comb begin
        n_out_data        = '0;
        n_out_data[31:0]  = rd;
        n_out_data[47:32] = (|rd[31:16]) ? SAT16 : rd[15:0];
        n_out_data[63:48] = n_boot;
        n_out_data[64]    = is_access && idx_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_boot      <= '0;
            r_latch     <= '0;
            r_press     <= '0;
            r_oper      <= '0;
            r_ms_rem    <= '0;
            r_wd_cnt    <= '0;
            r_wd_pend   <= 1'b0;
            r_tot_cnt   <= '0;
            r_tot_sec   <= '0;
            for (int i = 0; i < PRESETS; i++) begin
                r_on_cnt[i] <= '0;
                r_on_sec[i] <= '0;
            end
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            r_boot    <= n_boot;
            r_on_cnt  <= n_on_cnt;
            r_on_sec  <= n_on_sec;
            r_latch   <= n_latch;
            r_press   <= n_press;
            r_oper    <= n_oper;
            r_ms_rem  <= n_ms_rem;
            r_wd_cnt  <= n_wd_cnt;
            r_wd_pend <= n_wd_pend;
            r_tot_cnt <= n_tot_cnt;
            r_tot_sec <= n_tot_sec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_op     <= s_axis_tdata[3:0];
            r_preset <= s_axis_tdata[11:4];
            r_value  <= s_axis_tdata[43:12];
            r_cause  <= s_axis_tdata[59:44];
            r_index  <= s_axis_tdata[65:60];
        end
        if (advance) begin
            r_out_data <= n_out_data;
        end
    end

    `include "assert_macros.svh"

    `ASSERT_CLK(a_wd_boot_incr, i_clk, i_rst_n, advance && (r_op == OP_BOOT) && r_wd_pend && (r_wd_cnt != SAT16) |=> r_wd_cnt == $past(r_wd_cnt) + 16'd1, "watchdog count did not advance on boot")
    `ASSERT_CLK(a_clear_zeroes, i_clk, i_rst_n, advance && (r_op == OP_CLEAR) |=> (r_latch == '0) && (r_press == '0) && (r_ms_rem == '0) && (r_tot_cnt == '0) && (r_tot_sec == '0), "clear left a counter nonzero")
    `ASSERT_CLK(a_bad_index_zero, i_clk, i_rst_n, advance && is_access && !idx_ok |=> (m_axis_tdata[31:0] == '0) && !m_axis_tdata[64], "invalid index gave data or valid flag")
    `ASSERT_ALWAYS(a_ms_range, i_clk, !i_rst_n || (r_ms_rem <= MS_LAST) || $past(!i_rst_n), "millisecond remainder out of range")

endmodule
